FILE: hw/rtl/sndt_pkg.sv
package sndt_pkg;

    localparam int COORD_W    = 32;
    localparam int IN_DATA_W  = 12 * COORD_W;
    localparam int EDGE_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * EDGE_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int MAG_W      = PROD_W;
    localparam int LEN_W      = 7;
    localparam int M_W        = 31;
    localparam int SQ_W       = 64;
    localparam int ROOT_W     = 32;
    localparam int TOL_W      = 31;
    localparam int TOL_FRAC   = 30;
    localparam int TOLP_W     = TOL_W + ROOT_W;
    localparam int OUT_W      = 32;
    localparam int OUT_DATA_W = 296;
    localparam int OUT_FRAC_DEF = 30;

    localparam logic [TOL_W-1:0] TOL_RESET = 31'd18740330;

    typedef logic signed [EDGE_W-1:0] edge_t;

    // edge pair of one corner, cross product is u x v
    typedef struct packed {
        edge_t      ux;
        edge_t      uy;
        edge_t      uz;
        edge_t      vx;
        edge_t      vy;
        edge_t      vz;
        logic [1:0] node;
    } node_job_t;

endpackage

FILE: hw/rtl/sndt_issue.sv
module sndt_issue
    import sndt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 s_tvalid,
    input  logic [IN_DATA_W-1:0] s_tdata,
    output logic                 s_tready,
    output logic                 job_valid,
    output node_job_t            job
);

    logic signed [COORD_W-1:0] p [4][3];
    edge_t e21_next [3];
    edge_t e41_next [3];
    edge_t e32_next [3];
    edge_t e34_next [3];
    edge_t e21_reg [3];
    edge_t e41_reg [3];
    edge_t e32_reg [3];
    edge_t e34_reg [3];
    logic       busy_reg;
    logic [1:0] cnt_reg;
    logic       job_valid_reg;
    node_job_t  job_reg;
    node_job_t  job_next;
    logic       accept;

    assign s_tready = en & (~busy_reg | (cnt_reg == 2'd3));
    assign accept   = s_tvalid & s_tready;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < 3; i++) begin
                p[k][i] = signed'(s_tdata[(k*3+i)*COORD_W +: COORD_W]);
            end
        end
        for (int i = 0; i < 3; i++) begin
            e21_next[i] = EDGE_W'(p[1][i]) - EDGE_W'(p[0][i]);
            e41_next[i] = EDGE_W'(p[3][i]) - EDGE_W'(p[0][i]);
            e32_next[i] = EDGE_W'(p[2][i]) - EDGE_W'(p[1][i]);
            e34_next[i] = EDGE_W'(p[2][i]) - EDGE_W'(p[3][i]);
        end
    end

    // corners 0,1 use e21 as u, 2,3 use e34; corners 0,3 use e41 as v
    always_comb begin
        if (cnt_reg[1]) begin
            job_next.ux = e34_reg[0];
            job_next.uy = e34_reg[1];
            job_next.uz = e34_reg[2];
        end else begin
            job_next.ux = e21_reg[0];
            job_next.uy = e21_reg[1];
            job_next.uz = e21_reg[2];
        end
        if (cnt_reg[0] ^ cnt_reg[1]) begin
            job_next.vx = e32_reg[0];
            job_next.vy = e32_reg[1];
            job_next.vz = e32_reg[2];
        end else begin
            job_next.vx = e41_reg[0];
            job_next.vy = e41_reg[1];
            job_next.vz = e41_reg[2];
        end
        job_next.node = cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            cnt_reg       <= 2'd0;
            job_valid_reg <= 1'b0;
        end else if (en) begin
            job_valid_reg <= busy_reg;
            if (accept) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd0;
            end else if (busy_reg) begin
                if (cnt_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            job_reg <= job_next;
            if (accept) begin
                e21_reg <= e21_next;
                e41_reg <= e41_next;
                e32_reg <= e32_next;
                e34_reg <= e34_next;
            end
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

FILE: hw/rtl/sndt_isqrt.sv
module sndt_isqrt
    import sndt_pkg::*;
#(
    parameter int LANES = 3,
    parameter int SBW   = 1
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [SQ_W-1:0]   in_rad [LANES],
    input  logic [SBW-1:0]    in_sb,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root [LANES],
    output logic [SBW-1:0]    out_sb
);

    localparam int STEP  = 2;
    localparam int NST   = ROOT_W / STEP;
    localparam int REM_W = ROOT_W + 2;
    localparam int WRK_W = REM_W + 2;

    logic [NST-1:0]    valid_reg;
    logic [REM_W-1:0]  rem_reg   [NST][LANES];
    logic [REM_W-1:0]  rem_next  [NST][LANES];
    logic [ROOT_W-1:0] root_reg  [NST][LANES];
    logic [ROOT_W-1:0] root_next [NST][LANES];
    logic [SQ_W-1:0]   rad_reg   [NST][LANES];
    logic [SQ_W-1:0]   rad_next  [NST][LANES];
    logic [SBW-1:0]    sb_reg    [NST];

    // two result bits per stage, digit-by-digit square root
    always_comb begin
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [SQ_W-1:0]   rad;
        logic [WRK_W-1:0]  w;
        logic [WRK_W-1:0]  t;
        for (int s = 0; s < NST; s++) begin
            for (int l = 0; l < LANES; l++) begin
                if (s == 0) begin
                    rem  = '0;
                    root = '0;
                    rad  = in_rad[l];
                end else begin
                    rem  = rem_reg[s-1][l];
                    root = root_reg[s-1][l];
                    rad  = rad_reg[s-1][l];
                end
                for (int k = 0; k < STEP; k++) begin
                    w = {rem, rad[SQ_W-1 -: 2]};
                    t = WRK_W'({root, 2'b01});
                    if (w >= t) begin
                        w    = w - t;
                        root = {root[ROOT_W-2:0], 1'b1};
                    end else begin
                        root = {root[ROOT_W-2:0], 1'b0};
                    end
                    rem = w[REM_W-1:0];
                    rad = {rad[SQ_W-3:0], 2'b00};
                end
                rem_next[s][l]  = rem;
                root_next[s][l] = root;
                rad_next[s][l]  = rad;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg   <= rem_next;
            root_reg  <= root_next;
            rad_reg   <= rad_next;
            sb_reg[0] <= in_sb;
            for (int s = 1; s < NST; s++) begin
                sb_reg[s] <= sb_reg[s-1];
            end
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign out_root  = root_reg[NST-1];
    assign out_sb    = sb_reg[NST-1];

endmodule

FILE: hw/rtl/sndt_div.sv
module sndt_div
    import sndt_pkg::*;
#(
    parameter int LANES = 6,
    parameter int SBW   = 1,
    parameter int FRAC  = OUT_FRAC_DEF
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [ROOT_W-1:0] in_num [LANES],
    input  logic [ROOT_W-1:0] in_den [LANES],
    input  logic [SBW-1:0]    in_sb,
    output logic              out_valid,
    output logic [FRAC:0]     out_quo [LANES],
    output logic [SBW-1:0]    out_sb
);

    localparam int QB   = FRAC + 1;
    localparam int NW   = ROOT_W + 1 + FRAC;
    localparam int STEP = 2;
    localparam int NST  = (QB + STEP - 1) / STEP;
    localparam int DEP  = NST + 1;

    logic [DEP-1:0]    valid_reg;
    logic [ROOT_W-1:0] rem_reg  [DEP][LANES];
    logic [ROOT_W-1:0] rem_next [DEP][LANES];
    logic [QB-1:0]     low_reg  [DEP][LANES];
    logic [QB-1:0]     low_next [DEP][LANES];
    logic [ROOT_W-1:0] den_reg  [DEP][LANES];
    logic [ROOT_W-1:0] den_next [DEP][LANES];
    logic [SBW-1:0]    sb_reg   [DEP];

    // stage 0 forms num*2^FRAC + den/2; the upper part is already below den
    // since the quotient never exceeds 2^FRAC. Then restoring steps, low
    // bits shift out at the top while quotient bits shift in at the bottom.
    always_comb begin
        logic [NW-1:0]     n;
        logic [ROOT_W-1:0] rem;
        logic [QB-1:0]     low;
        logic [ROOT_W-1:0] d;
        logic [ROOT_W:0]   w;
        for (int l = 0; l < LANES; l++) begin
            n = (NW'(in_num[l]) << FRAC) + NW'(in_den[l] >> 1);
            rem_next[0][l] = n[NW-1:QB];
            low_next[0][l] = n[QB-1:0];
            den_next[0][l] = in_den[l];
        end
        for (int s = 1; s < DEP; s++) begin
            for (int l = 0; l < LANES; l++) begin
                rem = rem_reg[s-1][l];
                low = low_reg[s-1][l];
                d   = den_reg[s-1][l];
                for (int k = 0; k < STEP; k++) begin
                    if ((s - 1) * STEP + k < QB) begin
                        w = {rem, low[QB-1]};
                        if (w >= {1'b0, d}) begin
                            w   = w - {1'b0, d};
                            low = {low[QB-2:0], 1'b1};
                        end else begin
                            low = {low[QB-2:0], 1'b0};
                        end
                        rem = w[ROOT_W-1:0];
                    end
                end
                rem_next[s][l] = rem;
                low_next[s][l] = low;
                den_next[s][l] = d;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[DEP-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg   <= rem_next;
            low_reg   <= low_next;
            den_reg   <= den_next;
            sb_reg[0] <= in_sb;
            for (int s = 1; s < DEP; s++) begin
                sb_reg[s] <= sb_reg[s-1];
            end
        end
    end

    assign out_valid = valid_reg[DEP-1];
    assign out_quo   = low_reg[DEP-1];
    assign out_sb    = sb_reg[DEP-1];

endmodule

FILE: hw/rtl/shell_node_director_triad_unit.sv
// Channel   Dir  Ports                         Content
// s_        in   tvalid tready tdata[383:0]    one element, four corners
// m_        out  tvalid tready tdata[295:0]    one corner triad
//                tuser tlast                   degenerate, last corner
// cfg_      in   wr_en wr_data[30:0]           axis tolerance, Q1.30
//
// One element is taken at a time, the next as the last corner of the one
// before issues: the four corner triads leave one per cycle while m_tready
// does not stall, through the single result port, set by the corner
// sequencer. Most of the delay lies in the 16-stage square root and the pipelined divider.
// Reset (aresetn low, synchronous) clears the valid bits and restores
// the tolerance. A stall on m_tready freezes every stage in place.
module shell_node_director_triad_unit
    import sndt_pkg::*;
#(
    parameter int OUT_FRAC_BITS = OUT_FRAC_DEF
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // node1_x, node1_y, node1_z, node2_x, ... node4_z
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // node_index, first_x/y/z, second_x/y/z, normal_x/y/z, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    // degenerate
    output logic                  m_tuser,
    output logic                  m_tlast,
    input  logic                  cfg_wr_en,
    input  logic [TOL_W-1:0]      cfg_wr_data
);

    localparam int QB     = OUT_FRAC_BITS + 1;
    localparam int SQP_W  = 2 * M_W;
    localparam int SB1_W  = 2 + 1 + 3 + 3 * M_W;
    localparam int SB2_W  = 1 + 2 + 1 + 3;
    localparam int PAD_W  = OUT_DATA_W - 2 - 9 * OUT_W;
    localparam logic [2*QB-1:0] HALF = (2*QB)'(1) << (OUT_FRAC_BITS - 1);

    logic       en;
    logic [TOL_W-1:0] tol_reg;
    logic       job_valid;
    node_job_t  job;

    // valid bits
    logic p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg, p5_valid_reg;
    logic p6_valid_reg, p7_valid_reg, p8_valid_reg, p9_valid_reg, p10_valid_reg;
    logic m_tvalid_reg;

    logic signed [PROD_W-1:0] p1_prod_reg [6];
    logic [1:0]        p1_node_reg;
    logic [MAG_W-1:0]  p2_mag_reg [3];
    logic [2:0]        p2_neg_reg;
    logic [1:0]        p2_node_reg;
    logic [MAG_W-1:0]  p3_mag_reg [3];
    logic [MAG_W-1:0]  p3_or_reg;
    logic [2:0]        p3_neg_reg;
    logic [1:0]        p3_node_reg;
    logic [MAG_W-1:0]  p4_mag_reg [3];
    logic [LEN_W-1:0]  p4_len_reg;
    logic [LEN_W-1:0]  p4_len_next;
    logic [2:0]        p4_neg_reg;
    logic [1:0]        p4_node_reg;
    logic [M_W-1:0]    p5_m_reg [3];
    logic [M_W-1:0]    p5_m_next [3];
    logic [2:0]        p5_neg_reg;
    logic              p5_deg_reg;
    logic [1:0]        p5_node_reg;
    logic [SQP_W-1:0]  p6_sq_reg [3];
    logic [M_W-1:0]    p6_m_reg [3];
    logic [2:0]        p6_neg_reg;
    logic              p6_deg_reg;
    logic [1:0]        p6_node_reg;
    logic [SQ_W-1:0]   p7_rad_reg [3];
    logic [SB1_W-1:0]  p7_sb_reg;

    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root [3];
    logic [SB1_W-1:0]  sq_sb;

    logic [TOLP_W-1:0] p8_tolp_reg;
    logic [ROOT_W-1:0] p8_r3_reg, p8_a1_reg, p8_a2_reg;
    logic [SB1_W-1:0]  p8_sb_reg;

    logic [M_W-1:0]    p8_m [3];
    logic [2:0]        p8_neg;
    logic              p8_deg;
    logic [1:0]        p8_node;
    logic              p9_use_x;
    logic [ROOT_W-1:0] p9_asel;
    logic [ROOT_W-1:0] p9_num_reg [6];
    logic [ROOT_W-1:0] p9_den_reg [6];
    logic [SB2_W-1:0]  p9_sb_reg;

    logic              dv_valid;
    logic [QB-1:0]     dv_quo [6];
    logic [SB2_W-1:0]  dv_sb;

    logic [QB-1:0]     p10_q_reg [6];
    logic [2*QB-1:0]   p10_pp_reg, p10_pq_reg;
    logic [SB2_W-1:0]  p10_sb_reg;

    logic [QB-1:0]     qp, qq;
    logic [2*QB-1:0]   rp, rq;
    logic              o_use_x, o_deg;
    logic [1:0]        o_node;
    logic [2:0]        o_neg;
    logic [OUT_W-1:0]  fx, fy, fz, sx, sy, sz, nx, ny, nz;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_DATA_W-1:0] m_tdata_next;
    logic              m_tuser_reg, m_tlast_reg;

    function automatic logic [OUT_W-1:0] sgn(input logic neg, input logic [QB-1:0] m);
        logic [OUT_W-1:0] e;
        e = OUT_W'(m);
        return neg ? (~e + OUT_W'(1)) : e;
    endfunction

    // whole pipe advances together; output register frees it
    assign en = ~m_tvalid_reg | m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
        end else if (cfg_wr_en) begin
            tol_reg <= cfg_wr_data;
        end
    end

    sndt_issue u_issue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tready  (s_tready),
        .job_valid (job_valid),
        .job       (job)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            p5_valid_reg  <= 1'b0;
            p6_valid_reg  <= 1'b0;
            p7_valid_reg  <= 1'b0;
            p8_valid_reg  <= 1'b0;
            p9_valid_reg  <= 1'b0;
            p10_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else if (en) begin
            p1_valid_reg  <= job_valid;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            p4_valid_reg  <= p3_valid_reg;
            p5_valid_reg  <= p4_valid_reg;
            p6_valid_reg  <= p5_valid_reg;
            p7_valid_reg  <= p6_valid_reg;
            p8_valid_reg  <= sq_valid;
            p9_valid_reg  <= p8_valid_reg;
            p10_valid_reg <= dv_valid;
            m_tvalid_reg  <= p10_valid_reg;
        end
    end

    // leading one of the OR of magnitudes gives the length of the largest
    always_comb begin
        p4_len_next = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (p3_or_reg[i]) begin
                p4_len_next = LEN_W'(i + 1);
            end
        end
    end

    // scale so the largest magnitude sits in [2^30, 2^31)
    always_comb begin
        logic [MAG_W-1:0] sh;
        for (int i = 0; i < 3; i++) begin
            if (p4_len_reg > LEN_W'(M_W)) begin
                sh = p4_mag_reg[i] >> (p4_len_reg - LEN_W'(M_W));
            end else begin
                sh = p4_mag_reg[i] << (LEN_W'(M_W) - p4_len_reg);
            end
            p5_m_next[i] = sh[M_W-1:0];
        end
    end

    always_comb begin
        p8_m[0] = p8_sb_reg[M_W-1:0];
        p8_m[1] = p8_sb_reg[2*M_W-1:M_W];
        p8_m[2] = p8_sb_reg[3*M_W-1:2*M_W];
        p8_neg  = p8_sb_reg[3*M_W+2:3*M_W];
        p8_deg  = p8_sb_reg[3*M_W+3];
        p8_node = p8_sb_reg[3*M_W+5:3*M_W+4];
        p9_use_x = (SQ_W'(p8_a1_reg) << TOL_FRAC) >= SQ_W'(p8_tolp_reg);
        p9_asel  = p9_use_x ? p8_a1_reg : p8_a2_reg;
    end

    always_ff @(posedge aclk) begin
        logic signed [CROSS_W-1:0] c;
        if (en) begin
            // P1: partial products of the cross product
            p1_prod_reg[0] <= PROD_W'(job.uy) * PROD_W'(job.vz);
            p1_prod_reg[1] <= PROD_W'(job.uz) * PROD_W'(job.vy);
            p1_prod_reg[2] <= PROD_W'(job.uz) * PROD_W'(job.vx);
            p1_prod_reg[3] <= PROD_W'(job.ux) * PROD_W'(job.vz);
            p1_prod_reg[4] <= PROD_W'(job.ux) * PROD_W'(job.vy);
            p1_prod_reg[5] <= PROD_W'(job.uy) * PROD_W'(job.vx);
            p1_node_reg    <= job.node;
            // P2: exact components as sign and magnitude
            for (int i = 0; i < 3; i++) begin
                c = CROSS_W'(p1_prod_reg[2*i]) - CROSS_W'(p1_prod_reg[2*i+1]);
                p2_neg_reg[i] <= c[CROSS_W-1];
                p2_mag_reg[i] <= c[CROSS_W-1] ? MAG_W'(-c) : MAG_W'(c);
            end
            p2_node_reg <= p1_node_reg;
            // P3
            p3_mag_reg  <= p2_mag_reg;
            p3_or_reg   <= p2_mag_reg[0] | p2_mag_reg[1] | p2_mag_reg[2];
            p3_neg_reg  <= p2_neg_reg;
            p3_node_reg <= p2_node_reg;
            // P4
            p4_mag_reg  <= p3_mag_reg;
            p4_len_reg  <= p4_len_next;
            p4_neg_reg  <= p3_neg_reg;
            p4_node_reg <= p3_node_reg;
            // P5
            p5_m_reg    <= p5_m_next;
            p5_neg_reg  <= p4_neg_reg;
            p5_deg_reg  <= (p4_len_reg == '0);
            p5_node_reg <= p4_node_reg;
            // P6
            for (int i = 0; i < 3; i++) begin
                p6_sq_reg[i] <= SQP_W'(p5_m_reg[i]) * SQP_W'(p5_m_reg[i]);
            end
            p6_m_reg    <= p5_m_reg;
            p6_neg_reg  <= p5_neg_reg;
            p6_deg_reg  <= p5_deg_reg;
            p6_node_reg <= p5_node_reg;
            // P7: radicands for r3, a1, a2
            p7_rad_reg[0] <= SQ_W'(p6_sq_reg[0]) + SQ_W'(p6_sq_reg[1]) + SQ_W'(p6_sq_reg[2]);
            p7_rad_reg[1] <= SQ_W'(p6_sq_reg[1]) + SQ_W'(p6_sq_reg[2]);
            p7_rad_reg[2] <= SQ_W'(p6_sq_reg[0]) + SQ_W'(p6_sq_reg[2]);
            p7_sb_reg     <= {p6_node_reg, p6_deg_reg, p6_neg_reg,
                              p6_m_reg[2], p6_m_reg[1], p6_m_reg[0]};
            // P8: tolerance product
            p8_tolp_reg <= TOLP_W'(tol_reg) * TOLP_W'(sq_root[0]);
            p8_r3_reg   <= sq_root[0];
            p8_a1_reg   <= sq_root[1];
            p8_a2_reg   <= sq_root[2];
            p8_sb_reg   <= sq_sb;
            // P9: reference axis choice, divider operands
            p9_num_reg[0] <= ROOT_W'(p8_m[0]);
            p9_num_reg[1] <= ROOT_W'(p8_m[1]);
            p9_num_reg[2] <= ROOT_W'(p8_m[2]);
            p9_num_reg[3] <= p9_asel;
            p9_num_reg[4] <= p9_use_x ? ROOT_W'(p8_m[1]) : ROOT_W'(p8_m[0]);
            p9_num_reg[5] <= ROOT_W'(p8_m[2]);
            for (int i = 0; i < 4; i++) begin
                p9_den_reg[i] <= p8_r3_reg;
            end
            p9_den_reg[4] <= p9_asel;
            p9_den_reg[5] <= p9_asel;
            p9_sb_reg     <= {p9_use_x, p8_node, p8_deg | (p9_asel == '0), p8_neg};
            // P10: second column products
            p10_q_reg  <= dv_quo;
            p10_pp_reg <= (2*QB)'(dv_sb[SB2_W-1] ? dv_quo[0] : dv_quo[1])
                          * (2*QB)'(dv_quo[4]);
            p10_pq_reg <= (2*QB)'(dv_sb[SB2_W-1] ? dv_quo[0] : dv_quo[1])
                          * (2*QB)'(dv_quo[5]);
            p10_sb_reg <= dv_sb;
            // output register
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= o_deg;
            m_tlast_reg <= (o_node == 2'd3);
        end
    end

    sndt_isqrt #(
        .LANES (3),
        .SBW   (SB1_W)
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p7_valid_reg),
        .in_rad    (p7_rad_reg),
        .in_sb     (p7_sb_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_sb    (sq_sb)
    );

    sndt_div #(
        .LANES (6),
        .SBW   (SB2_W),
        .FRAC  (OUT_FRAC_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p9_valid_reg),
        .in_num    (p9_num_reg),
        .in_den    (p9_den_reg),
        .in_sb     (p9_sb_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_sb    (dv_sb)
    );

    // quotient lanes: 0..2 normal, 3 a/r3, 4 and 5 first column
    always_comb begin
        o_use_x = p10_sb_reg[6];
        o_node  = p10_sb_reg[5:4];
        o_deg   = p10_sb_reg[3];
        o_neg   = p10_sb_reg[2:0];
        rp = p10_pp_reg + HALF;
        rq = p10_pq_reg + HALF;
        qp = rp[OUT_FRAC_BITS +: QB];
        qq = rq[OUT_FRAC_BITS +: QB];
        nx = sgn(o_neg[0], p10_q_reg[0]);
        ny = sgn(o_neg[1], p10_q_reg[1]);
        nz = sgn(o_neg[2], p10_q_reg[2]);
        if (o_use_x) begin
            fx = '0;
            fy = sgn(~o_neg[2], p10_q_reg[5]);
            fz = sgn(o_neg[1], p10_q_reg[4]);
            sx = sgn(1'b0, p10_q_reg[3]);
            sy = sgn(~(o_neg[0] ^ o_neg[1]), qp);
            sz = sgn(~(o_neg[0] ^ o_neg[2]), qq);
        end else begin
            fx = sgn(o_neg[2], p10_q_reg[5]);
            fy = '0;
            fz = sgn(~o_neg[0], p10_q_reg[4]);
            sx = sgn(~(o_neg[0] ^ o_neg[1]), qp);
            sy = sgn(1'b0, p10_q_reg[3]);
            sz = sgn(~(o_neg[1] ^ o_neg[2]), qq);
        end
        if (o_deg) begin
            m_tdata_next = {{(OUT_DATA_W-2){1'b0}}, o_node};
        end else begin
            m_tdata_next = {{PAD_W{1'b0}}, nz, ny, nx, sz, sy, sx, fz, fy, fx, o_node};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[1:0] == 2'd3)
        else $error("last flag on a corner other than the fourth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[289:2] == '0)
        else $error("degenerate triad with nonzero matrix");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[225:194] | m_tdata[257:226]
                                  | m_tdata[289:258]) != '0)
        else $error("valid triad with zero normal");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !(m_tvalid && !m_tready))
        else $error("input transfer taken while the pipeline is stalled");

endmodule
